### rtl/awb_pkg.sv
// ----------------------------------------------------------------------------
// awb_pkg
// Shared widths, item codes and helpers for the auto white balance unit.
// ----------------------------------------------------------------------------
package awb_pkg;

  localparam int PIX_W       = 8;
  localparam int SUM_W       = 30;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int KIND_W      = 2;

  localparam logic [SUM_W-1:0]  SUM_LIMIT   = '1;
  localparam logic [PIX_W-1:0]  WHITE_LEVEL = '1;
  localparam logic [GAIN_W-1:0] GAIN_LIMIT  = '1;
  localparam logic [GAIN_W-1:0] GAIN_UNITY  =
    (GAIN_FRAC >= GAIN_W) ? GAIN_LIMIT : GAIN_W'(1 << GAIN_FRAC);

  localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FINAL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CORRECT = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
  } item_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [PIX_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(v);
    return s[SUM_W] ? SUM_LIMIT : s[SUM_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] apply_gain(input logic [PIX_W-1:0] c,
                                                  input logic [GAIN_W-1:0] g);
    logic [PIX_W+GAIN_W-1:0] p;
    logic [PIX_W+GAIN_W-1:0] s;
    p = (PIX_W+GAIN_W)'(c) * (PIX_W+GAIN_W)'(g);
    s = p >> GAIN_FRAC;
    return (s > (PIX_W+GAIN_W)'(WHITE_LEVEL)) ? WHITE_LEVEL : s[PIX_W-1:0];
  endfunction

endpackage

### rtl/auto_white_balance_unit.sv
// path: a correct request is stored in the queue, then its result is registered; a final
//   measure request reports its gains when the 16-step divider is done
// throughput: one request per cycle unless busy; a final measure request holds
//   the back part for the divider run while the 4-entry queue takes up to 4 more requests
// reset: synchronous active low; statistics cleared, gains unity, mode 0
// ----------------------------------------------------------------------------
// auto_white_balance_unit
// Gray world / white patch white balance with measure and correct passes.
// ----------------------------------------------------------------------------
module auto_white_balance_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [awb_pkg::PIX_W-1:0]   in_red_in,
  input  logic [awb_pkg::PIX_W-1:0]   in_green_in,
  input  logic [awb_pkg::PIX_W-1:0]   in_blue_in,
  input  logic                        in_last_pixel,
  output logic                        out_valid,
  output logic                        out_result_kind,
  output logic [awb_pkg::PIX_W-1:0]   out_red_out,
  output logic [awb_pkg::PIX_W-1:0]   out_green_out,
  output logic [awb_pkg::PIX_W-1:0]   out_blue_out,
  output logic [awb_pkg::GAIN_W-1:0]  out_gain_red,
  output logic [awb_pkg::GAIN_W-1:0]  out_gain_blue
);

  awb_pkg::item_t front_item;
  awb_pkg::item_t back_item;
  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_empty;

  awb_front u_front (
    .start      (start),
    .busy       (busy),
    .operation  (in_operation),
    .red_in     (in_red_in),
    .green_in   (in_green_in),
    .blue_in    (in_blue_in),
    .last_pixel (in_last_pixel),
    .queue_full (queue_full),
    .push       (push),
    .item       (front_item)
  );

  awb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_item),
    .pop   (pop),
    .rdata (back_item),
    .full  (queue_full),
    .empty (queue_empty)
  );

  awb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .queue_empty     (queue_empty),
    .item            (back_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_gain_red    (out_gain_red),
    .out_gain_blue   (out_gain_blue)
  );

endmodule

### rtl/awb_div.sv
// ----------------------------------------------------------------------------
// awb_div
// Restoring divider for one gain, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module awb_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [awb_pkg::SUM_W-1:0]   num,
  input  logic [awb_pkg::SUM_W-1:0]   den,
  output logic                        done,
  output logic [awb_pkg::GAIN_W-1:0]  quot
);

  localparam int N_W   = awb_pkg::SUM_W + awb_pkg::GAIN_FRAC;
  localparam int REM_W = awb_pkg::SUM_W + 1;
  localparam int OVF_W = awb_pkg::SUM_W + awb_pkg::GAIN_W - awb_pkg::GAIN_FRAC + 1;
  localparam int CNT_W = $clog2(awb_pkg::GAIN_W + 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       sat_r, sat_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [REM_W-1:0]           rem_r, rem_nxt;
  logic [awb_pkg::GAIN_W-1:0] low_r, low_nxt;
  logic [awb_pkg::SUM_W-1:0]  den_r, den_nxt;

  logic [N_W-1:0]   n_full;
  logic [OVF_W-1:0] den_scaled;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             ge;

  always_comb begin
    n_full     = N_W'(num) << awb_pkg::GAIN_FRAC;
    den_scaled = OVF_W'(den) << (awb_pkg::GAIN_W - awb_pkg::GAIN_FRAC);
    trial      = {rem_r[awb_pkg::SUM_W-1:0], low_r[awb_pkg::GAIN_W-1]};
    ge         = trial >= {1'b0, den_r};
    diff       = trial - {1'b0, den_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    den_nxt  = den_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(awb_pkg::GAIN_W);
      sat_nxt  = OVF_W'(num) >= den_scaled;
      rem_nxt  = REM_W'(n_full[N_W-1:awb_pkg::GAIN_W]);
      low_nxt  = n_full[awb_pkg::GAIN_W-1:0];
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff : trial;
      low_nxt = {low_r[awb_pkg::GAIN_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sat_r <= sat_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = sat_r ? awb_pkg::GAIN_LIMIT : low_r;

endmodule

### rtl/awb_fifo.sv
// ----------------------------------------------------------------------------
// awb_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module awb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  awb_pkg::item_t wdata,
  input  logic           pop,
  output awb_pkg::item_t rdata,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = $clog2(awb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(awb_pkg::QUEUE_DEPTH + 1);

  awb_pkg::item_t   mem_r [awb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign full  = count_r == CNT_W'(awb_pkg::QUEUE_DEPTH);
  assign empty = count_r == '0;

endmodule

### rtl/awb_front.sv
// ----------------------------------------------------------------------------
// awb_front
// Request intake: handshake and classification into measure, final, correct.
// ----------------------------------------------------------------------------
module awb_front (
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation,
  input  logic [awb_pkg::PIX_W-1:0]  red_in,
  input  logic [awb_pkg::PIX_W-1:0]  green_in,
  input  logic [awb_pkg::PIX_W-1:0]  blue_in,
  input  logic                       last_pixel,
  input  logic                       queue_full,
  output logic                       push,
  output awb_pkg::item_t             item
);

  always_comb begin
    busy  = queue_full;
    push  = start && !queue_full;
    if (operation) begin
      item.kind = awb_pkg::KIND_CORRECT;
    end else if (last_pixel) begin
      item.kind = awb_pkg::KIND_FINAL;
    end else begin
      item.kind = awb_pkg::KIND_MEASURE;
    end
    item.red   = red_in;
    item.green = green_in;
    item.blue  = blue_in;
  end

endmodule

### rtl/awb_back.sv
// ----------------------------------------------------------------------------
// awb_back
// Execution: statistics, gain computation and pixel correction.
// ----------------------------------------------------------------------------
module awb_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_data,
  input  logic                        queue_empty,
  input  awb_pkg::item_t              item,
  output logic                        pop,
  output logic                        out_valid,
  output logic                        out_result_kind,
  output logic [awb_pkg::PIX_W-1:0]   out_red_out,
  output logic [awb_pkg::PIX_W-1:0]   out_green_out,
  output logic [awb_pkg::PIX_W-1:0]   out_blue_out,
  output logic [awb_pkg::GAIN_W-1:0]  out_gain_red,
  output logic [awb_pkg::GAIN_W-1:0]  out_gain_blue
);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic state_r, state_nxt;
  logic mode_r, mode_nxt;

  logic [awb_pkg::SUM_W-1:0]  sum_red_r, sum_red_nxt;
  logic [awb_pkg::SUM_W-1:0]  sum_green_r, sum_green_nxt;
  logic [awb_pkg::SUM_W-1:0]  sum_blue_r, sum_blue_nxt;
  logic [awb_pkg::PIX_W-1:0]  max_red_r, max_red_nxt;
  logic [awb_pkg::PIX_W-1:0]  max_blue_r, max_blue_nxt;
  logic [awb_pkg::GAIN_W-1:0] gain_red_r, gain_red_nxt;
  logic [awb_pkg::GAIN_W-1:0] gain_blue_r, gain_blue_nxt;

  logic                       valid_r, valid_nxt;
  logic                       kind_r, kind_nxt;
  logic [awb_pkg::PIX_W-1:0]  red_r, red_nxt;
  logic [awb_pkg::PIX_W-1:0]  green_r, green_nxt;
  logic [awb_pkg::PIX_W-1:0]  blue_r, blue_nxt;
  logic [awb_pkg::GAIN_W-1:0] ogain_red_r, ogain_red_nxt;
  logic [awb_pkg::GAIN_W-1:0] ogain_blue_r, ogain_blue_nxt;

  logic [awb_pkg::SUM_W-1:0]  upd_red, upd_green, upd_blue;
  logic [awb_pkg::PIX_W-1:0]  upd_max_red, upd_max_blue;
  logic                       div_start;
  logic [awb_pkg::SUM_W-1:0]  num_red, den_red, num_blue, den_blue;
  logic                       done_red, done_blue;
  logic [awb_pkg::GAIN_W-1:0] quot_red, quot_blue;

  awb_div u_div_red (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_red),
    .den   (den_red),
    .done  (done_red),
    .quot  (quot_red)
  );

  awb_div u_div_blue (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_blue),
    .den   (den_blue),
    .done  (done_blue),
    .quot  (quot_blue)
  );

  always_comb begin
    upd_red      = awb_pkg::sat_add(sum_red_r, item.red);
    upd_green    = awb_pkg::sat_add(sum_green_r, item.green);
    upd_blue     = awb_pkg::sat_add(sum_blue_r, item.blue);
    upd_max_red  = (item.red > max_red_r) ? item.red : max_red_r;
    upd_max_blue = (item.blue > max_blue_r) ? item.blue : max_blue_r;

    if (mode_r) begin
      num_red  = awb_pkg::SUM_W'(awb_pkg::WHITE_LEVEL);
      den_red  = awb_pkg::SUM_W'(upd_max_red);
      num_blue = awb_pkg::SUM_W'(awb_pkg::WHITE_LEVEL);
      den_blue = awb_pkg::SUM_W'(upd_max_blue);
    end else begin
      num_red  = upd_green;
      den_red  = upd_red;
      num_blue = upd_green;
      den_blue = upd_blue;
    end

    pop       = (state_r == ST_RUN) && !queue_empty;
    div_start = 1'b0;
    state_nxt = state_r;
    mode_nxt  = cfg_we ? cfg_data : mode_r;

    sum_red_nxt   = sum_red_r;
    sum_green_nxt = sum_green_r;
    sum_blue_nxt  = sum_blue_r;
    max_red_nxt   = max_red_r;
    max_blue_nxt  = max_blue_r;
    gain_red_nxt  = gain_red_r;
    gain_blue_nxt = gain_blue_r;

    valid_nxt      = 1'b0;
    kind_nxt       = kind_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    blue_nxt       = blue_r;
    ogain_red_nxt  = ogain_red_r;
    ogain_blue_nxt = ogain_blue_r;

    case (state_r)
      ST_RUN: begin
        if (pop) begin
          case (item.kind)
            awb_pkg::KIND_MEASURE: begin
              sum_red_nxt   = upd_red;
              sum_green_nxt = upd_green;
              sum_blue_nxt  = upd_blue;
              max_red_nxt   = upd_max_red;
              max_blue_nxt  = upd_max_blue;
            end
            awb_pkg::KIND_FINAL: begin
              div_start     = 1'b1;
              sum_red_nxt   = '0;
              sum_green_nxt = '0;
              sum_blue_nxt  = '0;
              max_red_nxt   = '0;
              max_blue_nxt  = '0;
              state_nxt     = ST_DIV;
            end
            awb_pkg::KIND_CORRECT: begin
              valid_nxt      = 1'b1;
              kind_nxt       = 1'b0;
              red_nxt        = awb_pkg::apply_gain(item.red, gain_red_r);
              green_nxt      = item.green;
              blue_nxt       = awb_pkg::apply_gain(item.blue, gain_blue_r);
              ogain_red_nxt  = gain_red_r;
              ogain_blue_nxt = gain_blue_r;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (done_red && done_blue) begin
          gain_red_nxt   = quot_red;
          gain_blue_nxt  = quot_blue;
          valid_nxt      = 1'b1;
          kind_nxt       = 1'b1;
          red_nxt        = '0;
          green_nxt      = '0;
          blue_nxt       = '0;
          ogain_red_nxt  = quot_red;
          ogain_blue_nxt = quot_blue;
          state_nxt      = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      mode_r      <= 1'b0;
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
      max_red_r   <= '0;
      max_blue_r  <= '0;
      gain_red_r  <= awb_pkg::GAIN_UNITY;
      gain_blue_r <= awb_pkg::GAIN_UNITY;
      valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      sum_red_r   <= sum_red_nxt;
      sum_green_r <= sum_green_nxt;
      sum_blue_r  <= sum_blue_nxt;
      max_red_r   <= max_red_nxt;
      max_blue_r  <= max_blue_nxt;
      gain_red_r  <= gain_red_nxt;
      gain_blue_r <= gain_blue_nxt;
      valid_r     <= valid_nxt;
    end
    kind_r       <= kind_nxt;
    red_r        <= red_nxt;
    green_r      <= green_nxt;
    blue_r       <= blue_nxt;
    ogain_red_r  <= ogain_red_nxt;
    ogain_blue_r <= ogain_blue_nxt;
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_red_out     = red_r;
  assign out_green_out   = green_r;
  assign out_blue_out    = blue_r;
  assign out_gain_red    = ogain_red_r;
  assign out_gain_blue   = ogain_blue_r;

endmodule

### rtl/awb_checker.sv
// ----------------------------------------------------------------------------
// awb_checker
// Port-level checks on the auto white balance unit.
// ----------------------------------------------------------------------------
module awb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        busy,
  input logic                        out_valid,
  input logic                        out_result_kind,
  input logic [awb_pkg::PIX_W-1:0]   out_red_out,
  input logic [awb_pkg::PIX_W-1:0]   out_green_out,
  input logic [awb_pkg::PIX_W-1:0]   out_blue_out,
  input logic [awb_pkg::GAIN_W-1:0]  out_gain_red,
  input logic [awb_pkg::GAIN_W-1:0]  out_gain_blue
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |->
      out_red_out == '0 && out_green_out == '0 && out_blue_out == '0)
    else $error("gain report carries pixel data");

  a_gain_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind && $past(out_valid && !out_result_kind) |->
      $stable(out_gain_red) && $stable(out_gain_blue))
    else $error("gains changed between corrected pixels without a report");

endmodule

bind auto_white_balance_unit awb_checker u_awb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_red_out     (out_red_out),
  .out_green_out   (out_green_out),
  .out_blue_out    (out_blue_out),
  .out_gain_red    (out_gain_red),
  .out_gain_blue   (out_gain_blue)
);

### tb/sv/tb_auto_white_balance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_auto_white_balance_unit
// Self-checking bench for the auto white balance unit. A short table of
// directed requests (extreme pixels, saturating gains, both balance
// modes) is followed by random measure and correct frames with bursty
// pacing. Every result is compared field by field, with the table's own
// values for typed rows and otherwise with a local model of statistics and gains.
// ----------------------------------------------------------------------------
module tb_auto_white_balance_unit;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CORRECT = 1'b1;
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_GAINS = 1'b1;
  localparam logic MODE_GRAY  = 1'b0;
  localparam logic MODE_PATCH = 1'b1;

  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 750;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int DIR_ROWS      = 23;

  localparam longint unsigned ACC_CEIL  = (64'd1 << awb_pkg::SUM_W) - 1;
  localparam longint unsigned GAIN_CEIL = (64'd1 << awb_pkg::GAIN_W) - 1;
  localparam logic [awb_pkg::GAIN_W-1:0] GAIN_ONE =
    (awb_pkg::GAIN_FRAC >= awb_pkg::GAIN_W) ? awb_pkg::GAIN_W'(GAIN_CEIL) :
                                              awb_pkg::GAIN_W'(64'd1 << awb_pkg::GAIN_FRAC);

  typedef struct packed {
    logic                       kind;
    logic [awb_pkg::PIX_W-1:0]  red;
    logic [awb_pkg::PIX_W-1:0]  green;
    logic [awb_pkg::PIX_W-1:0]  blue;
    logic [awb_pkg::GAIN_W-1:0] gain_red;
    logic [awb_pkg::GAIN_W-1:0] gain_blue;
  } awb_out_t;

  typedef struct packed {
    logic                       cfg_wr;
    logic                       cfg_val;
    logic                       op;
    logic [awb_pkg::PIX_W-1:0]  red;
    logic [awb_pkg::PIX_W-1:0]  green;
    logic [awb_pkg::PIX_W-1:0]  blue;
    logic                       last;
    logic                       typed;
    logic                       kind;
    logic [awb_pkg::PIX_W-1:0]  exp_red;
    logic [awb_pkg::PIX_W-1:0]  exp_green;
    logic [awb_pkg::PIX_W-1:0]  exp_blue;
    logic [awb_pkg::GAIN_W-1:0] exp_gain_red;
    logic [awb_pkg::GAIN_W-1:0] exp_gain_blue;
  } stim_row_t;

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       cfg_we        = 1'b0;
  logic                       cfg_data      = 1'b0;
  logic                       start         = 1'b0;
  logic                       in_operation  = 1'b0;
  logic [awb_pkg::PIX_W-1:0]  in_red_in     = '0;
  logic [awb_pkg::PIX_W-1:0]  in_green_in   = '0;
  logic [awb_pkg::PIX_W-1:0]  in_blue_in    = '0;
  logic                       in_last_pixel = 1'b0;
  logic                       busy;
  logic                       out_valid;
  logic                       out_result_kind;
  logic [awb_pkg::PIX_W-1:0]  out_red_out;
  logic [awb_pkg::PIX_W-1:0]  out_green_out;
  logic [awb_pkg::PIX_W-1:0]  out_blue_out;
  logic [awb_pkg::GAIN_W-1:0] out_gain_red;
  logic [awb_pkg::GAIN_W-1:0] out_gain_blue;

  auto_white_balance_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .in_last_pixel   (in_last_pixel),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_gain_red    (out_gain_red),
    .out_gain_blue   (out_gain_blue)
  );

  // local copy of mode, statistics and gains
  logic                       mode_q;
  logic [awb_pkg::SUM_W-1:0]  acc_r, acc_g, acc_b;
  logic [awb_pkg::PIX_W-1:0]  peak_r, peak_b;
  logic [awb_pkg::GAIN_W-1:0] gain_r, gain_b;

  awb_out_t owed_outputs[$];
  int       fault_count = 0;
  int       items_sent  = 0;
  int       burst_left  = 0;

  stim_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{0, 0, OP_CORRECT, 255, 128,   0, 0, 1, KIND_PIXEL, 255, 128,   0,  4096,  4096},
    '{0, 0, OP_CORRECT,   0, 255, 255, 1, 1, KIND_PIXEL,   0, 255, 255,  4096,  4096},
    '{1, MODE_GRAY, OP_MEASURE, 0, 0, 0, 1, 1, KIND_GAINS, 0, 0, 0,     65535, 65535},
    '{0, 0, OP_CORRECT, 255,   7,   1, 0, 1, KIND_PIXEL, 255,   7,  15, 65535, 65535},
    '{0, 0, OP_CORRECT,   0,   0,   0, 1, 1, KIND_PIXEL,   0,   0,   0, 65535, 65535},
    '{0, 0, OP_MEASURE, 128, 128, 128, 0, 0, KIND_PIXEL,   0,   0,   0,     0,     0},
    '{0, 0, OP_MEASURE, 128, 128, 128, 1, 1, KIND_GAINS,   0,   0,   0,  4096,  4096},
    '{0, 0, OP_MEASURE,   1, 255, 255, 1, 1, KIND_GAINS,   0,   0,   0, 65535,  4096},
    '{0, 0, OP_CORRECT,   3, 200, 255, 0, 1, KIND_PIXEL,  47, 200, 255, 65535,  4096},
    '{1, MODE_PATCH, OP_MEASURE, 0, 77, 0, 1, 1, KIND_GAINS, 0, 0, 0,   65535, 65535},
    '{0, 0, OP_MEASURE, 255,   0, 255, 0, 0, KIND_PIXEL,   0,   0,   0,     0,     0},
    '{0, 0, OP_MEASURE,   1,   0,   1, 1, 1, KIND_GAINS,   0,   0,   0,  4096,  4096},
    '{0, 0, OP_MEASURE,   1,   0, 255, 1, 1, KIND_GAINS,   0,   0,   0, 65535,  4096},
    '{0, 0, OP_MEASURE,  51,   9,  85, 1, 1, KIND_GAINS,   0,   0,   0, 20480, 12288},
    '{0, 0, OP_CORRECT, 200,  33,  10, 0, 1, KIND_PIXEL, 255,  33,  30, 20480, 12288},
    '{0, 0, OP_CORRECT,   1,   1,   1, 1, 0, KIND_PIXEL,   0,   0,   0,     0,     0},
    '{0, 0, OP_MEASURE,  17, 250,   3, 0, 0, KIND_PIXEL,   0,   0,   0,     0,     0},
    '{0, 0, OP_MEASURE,  90,   4, 200, 1, 0, KIND_PIXEL,   0,   0,   0,     0,     0},
    '{1, MODE_GRAY, OP_MEASURE, 37, 200, 91, 0, 0, KIND_PIXEL, 0, 0, 0,     0,     0},
    '{0, 0, OP_MEASURE, 255, 255, 255, 0, 0, KIND_PIXEL,   0,   0,   0,     0,     0},
    '{0, 0, OP_MEASURE,  12,   3, 250, 1, 0, KIND_PIXEL,   0,   0,   0,     0,     0},
    '{0, 0, OP_CORRECT, 123,  45,  67, 0, 0, KIND_PIXEL,   0,   0,   0,     0,     0},
    '{0, 0, OP_CORRECT, 255, 255, 255, 0, 0, KIND_PIXEL,   0,   0,   0,     0,     0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("FAIL");
    $finish;
  end

  function automatic logic [awb_pkg::SUM_W-1:0] acc_add(
      input logic [awb_pkg::SUM_W-1:0] acc, input logic [awb_pkg::PIX_W-1:0] v);
    longint unsigned total;
    total = longint'(acc) + longint'(v);
    return (total > ACC_CEIL) ? awb_pkg::SUM_W'(ACC_CEIL) : total[awb_pkg::SUM_W-1:0];
  endfunction

  function automatic logic [awb_pkg::GAIN_W-1:0] ratio_gain(input longint unsigned num,
                                                            input longint unsigned den);
    longint unsigned q;
    if (den == 0) begin
      return awb_pkg::GAIN_W'(GAIN_CEIL);
    end
    q = (num << awb_pkg::GAIN_FRAC) / den;
    return (q > GAIN_CEIL) ? awb_pkg::GAIN_W'(GAIN_CEIL) : q[awb_pkg::GAIN_W-1:0];
  endfunction

  function automatic logic [awb_pkg::PIX_W-1:0] scale_channel(
      input logic [awb_pkg::PIX_W-1:0] c, input logic [awb_pkg::GAIN_W-1:0] g);
    longint unsigned p;
    p = (longint'(c) * longint'(g)) >> awb_pkg::GAIN_FRAC;
    return (p > 255) ? 8'd255 : p[awb_pkg::PIX_W-1:0];
  endfunction

  function automatic logic [awb_pkg::PIX_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return awb_pkg::PIX_W'($urandom_range(0, 3));
      default: return awb_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic predict_balance(input logic op, input logic [awb_pkg::PIX_W-1:0] r,
                                 input logic [awb_pkg::PIX_W-1:0] g,
                                 input logic [awb_pkg::PIX_W-1:0] b,
                                 input logic last, output bit produced,
                                 output awb_out_t res);
    res = '0;
    produced = 1'b0;
    if (op == OP_CORRECT) begin
      res = {KIND_PIXEL, scale_channel(r, gain_r), g, scale_channel(b, gain_b),
             gain_r, gain_b};
      produced = 1'b1;
    end else begin
      acc_r = acc_add(acc_r, r);
      acc_g = acc_add(acc_g, g);
      acc_b = acc_add(acc_b, b);
      if (r > peak_r) peak_r = r;
      if (b > peak_b) peak_b = b;
      if (last) begin
        if (mode_q == MODE_GRAY) begin
          gain_r = ratio_gain(64'(acc_g), 64'(acc_r));
          gain_b = ratio_gain(64'(acc_g), 64'(acc_b));
        end else begin
          gain_r = ratio_gain(64'(awb_pkg::WHITE_LEVEL), 64'(peak_r));
          gain_b = ratio_gain(64'(awb_pkg::WHITE_LEVEL), 64'(peak_b));
        end
        acc_r = '0;
        acc_g = '0;
        acc_b = '0;
        peak_r = '0;
        peak_b = '0;
        res = {KIND_GAINS, 8'd0, 8'd0, 8'd0, gain_r, gain_b};
        produced = 1'b1;
      end
    end
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 40);
      else if ($urandom_range(0, 2) == 0) gap = 0;
      else gap = $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_request(input logic op, input logic [awb_pkg::PIX_W-1:0] r,
                              input logic [awb_pkg::PIX_W-1:0] g,
                              input logic [awb_pkg::PIX_W-1:0] b,
                              input logic last, input bit typed,
                              input awb_out_t typed_res);
    bit       produced;
    awb_out_t res;
    pace_sender();
    start         <= 1'b1;
    in_operation  <= op;
    in_red_in     <= r;
    in_green_in   <= g;
    in_blue_in    <= b;
    in_last_pixel <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_balance(op, r, g, b, last, produced, res);
    if (produced) owed_outputs.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic wait_idle();
    while (owed_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    start <= 1'b0;
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q = v;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    awb_out_t seen;
    awb_out_t want;
    if (rst_n && out_valid) begin
      seen = {out_result_kind, out_red_out, out_green_out, out_blue_out,
              out_gain_red, out_gain_blue};
      if (owed_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d rgb %0d %0d %0d",
                 $time, seen.kind, seen.red, seen.green, seen.blue);
        fault_count++;
      end else begin
        want = owed_outputs.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(seen.kind));
        check_field("red_out", 32'(want.red), 32'(seen.red));
        check_field("green_out", 32'(want.green), 32'(seen.green));
        check_field("blue_out", 32'(want.blue), 32'(seen.blue));
        check_field("gain_red", 32'(want.gain_red), 32'(seen.gain_red));
        check_field("gain_blue", 32'(want.gain_blue), 32'(seen.gain_blue));
      end
    end
  end

  initial begin
    stim_row_t row;
    int        goal;
    int        n;
    int        style;
    mode_q = MODE_GRAY;
    acc_r  = '0;
    acc_g  = '0;
    acc_b  = '0;
    peak_r = '0;
    peak_b = '0;
    gain_r = GAIN_ONE;
    gain_b = GAIN_ONE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++) begin
      row = dir_rows[k];
      if (row.cfg_wr) write_mode(row.cfg_val);
      send_request(row.op, row.red, row.green, row.blue, row.last, row.typed,
                   {row.kind, row.exp_red, row.exp_green, row.exp_blue,
                    row.exp_gain_red, row.exp_gain_blue});
    end

    // random frames: mostly a measure pass closed by last_pixel, then a correct pass
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      style = $urandom_range(0, 9);
      if (style == 0) begin
        for (int i = 0; i < n; i++) begin
          send_request(1'($urandom_range(0, 1)), pick_level(), pick_level(),
                       pick_level(), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end else begin
        for (int i = 0; i < n; i++) begin
          send_request(OP_MEASURE, pick_level(), pick_level(), pick_level(),
                       (style != 1) && (i == n - 1), 1'b0, '0);
        end
        for (int i = 0; i < n; i++) begin
          send_request(OP_CORRECT, pick_level(), pick_level(), pick_level(),
                       1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
    end

    start <= 1'b0;
    wait_idle();
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
